/* src/utv_pkg.sv */
// Shared types and constants for the UTF-8 text validator.
`timescale 1ns / 1ps

package utv_pkg;

  // Special lead byte of the open sequence; each class has its own second-byte rule.
  typedef enum logic [2:0] {
    LEAD_NONE = 3'd0,
    LEAD_C2   = 3'd1,
    LEAD_E0   = 3'd2,
    LEAD_ED   = 3'd3,
    LEAD_F0   = 3'd4,
    LEAD_F4   = 3'd5
  } lead_t;

  // Sequence state carried from one byte to the next.
  typedef struct packed {
    logic [1:0] bytes_pending;
    lead_t      lead_class;
    logic       expect_second;
    logic       error_seen;
  } utv_state_t;

  localparam utv_state_t STATE_RESET = '{
    bytes_pending: 2'd0,
    lead_class:    LEAD_NONE,
    expect_second: 1'b0,
    error_seen:    1'b0
  };

  // Byte values used by the validation rules.
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_LF      = 8'h0a;
  localparam logic [7:0] BYTE_CR      = 8'h0d;
  localparam logic [7:0] BYTE_DEL     = 8'h7f;
  localparam logic [7:0] BYTE_CONT    = 8'h80;
  localparam logic [7:0] BYTE_C1_TOP  = 8'h9f;
  localparam logic [7:0] BYTE_A0      = 8'ha0;
  localparam logic [7:0] BYTE_90      = 8'h90;
  localparam logic [7:0] BYTE_C0      = 8'hc0;
  localparam logic [7:0] LEAD2_FIRST  = 8'hc2;
  localparam logic [7:0] LEAD2_LAST   = 8'hdf;
  localparam logic [7:0] LEAD3_FIRST  = 8'he0;
  localparam logic [7:0] LEAD3_SURR   = 8'hed;
  localparam logic [7:0] LEAD3_LAST   = 8'hef;
  localparam logic [7:0] LEAD4_FIRST  = 8'hf0;
  localparam logic [7:0] LEAD4_LAST   = 8'hf4;

endpackage

/* src/utv_if.sv */
// Valid/ready channel interfaces for the byte input and the verdict output.
`timescale 1ns / 1ps

interface utv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utv_out_if;
  logic valid;
  logic ready;
  logic text_ok;

  modport source (output valid, output text_ok, input ready);
  modport sink   (input valid, input text_ok, output ready);
endinterface

/* src/utv_step.sv */
// Per-byte state update and end-of-message verdict.
`timescale 1ns / 1ps

module utv_step
  import utv_pkg::*;
(
  input  utv_state_t cur_state,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output utv_state_t nxt_state,
  output logic       text_ok
);

  logic       second_ok;
  logic       is_cont;
  logic       is_ctrl;
  utv_state_t upd;

  // Second-byte range rule for the special lead bytes.
  always_comb begin
    unique case (cur_state.lead_class)
      LEAD_C2: second_ok = (data_byte > BYTE_C1_TOP);
      LEAD_E0: second_ok = (data_byte >= BYTE_A0);
      LEAD_ED: second_ok = (data_byte < BYTE_A0);
      LEAD_F0: second_ok = (data_byte >= BYTE_90);
      LEAD_F4: second_ok = (data_byte < BYTE_90);
      default: second_ok = 1'b1;
    endcase
  end

  assign is_cont = ((data_byte & BYTE_C0) == BYTE_CONT);
  assign is_ctrl = ((data_byte < BYTE_SPACE) && (data_byte != BYTE_TAB) &&
                    (data_byte != BYTE_LF) && (data_byte != BYTE_CR)) ||
                   (data_byte == BYTE_DEL);

  // Sequence tracking; any broken rule sets the sticky error and clears the sequence.
  always_comb begin
    upd = cur_state;
    if (!cur_state.error_seen) begin
      if (cur_state.bytes_pending != 2'd0) begin
        if (!is_cont || (cur_state.expect_second && !second_ok)) begin
          upd = STATE_RESET;
          upd.error_seen = 1'b1;
        end else begin
          upd.expect_second = 1'b0;
          upd.bytes_pending = cur_state.bytes_pending - 2'd1;
          if (cur_state.bytes_pending == 2'd1) begin
            upd.lead_class = LEAD_NONE;
          end
        end
      end else if (!data_byte[7]) begin
        if (is_ctrl) begin
          upd.error_seen = 1'b1;
        end
      end else if ((data_byte >= LEAD2_FIRST) && (data_byte <= LEAD2_LAST)) begin
        upd.bytes_pending = 2'd1;
        upd.lead_class    = (data_byte == LEAD2_FIRST) ? LEAD_C2 : LEAD_NONE;
        upd.expect_second = 1'b1;
      end else if ((data_byte >= LEAD3_FIRST) && (data_byte <= LEAD3_LAST)) begin
        upd.bytes_pending = 2'd2;
        upd.lead_class    = (data_byte == LEAD3_FIRST) ? LEAD_E0 :
                            (data_byte == LEAD3_SURR)  ? LEAD_ED : LEAD_NONE;
        upd.expect_second = 1'b1;
      end else if ((data_byte >= LEAD4_FIRST) && (data_byte <= LEAD4_LAST)) begin
        upd.bytes_pending = 2'd3;
        upd.lead_class    = (data_byte == LEAD4_FIRST) ? LEAD_F0 :
                            (data_byte == LEAD4_LAST)  ? LEAD_F4 : LEAD_NONE;
        upd.expect_second = 1'b1;
      end else begin
        upd = STATE_RESET;
        upd.error_seen = 1'b1;
      end
    end
  end

  // The message passes only with no error and no open sequence; the last byte restarts state.
  assign text_ok   = !upd.error_seen && (upd.bytes_pending == 2'd0);
  assign nxt_state = last_byte ? STATE_RESET : upd;

endmodule

/* src/utf8_text_validator_core.sv */
// Top level of the UTF-8 text validator: input register, step logic, verdict register.
//
// Usage:
//   in_beat carries one message byte per beat (data_byte) and marks the final byte
//   with last_byte. out_beat carries one verdict (text_ok) per message, produced
//   only for the beat marked last; text_ok is 1 when the whole message is
//   well-formed, showable UTF-8 text.
//   Throughput is one byte per cycle unless a last byte waits behind a held
//   verdict. A byte is registered on acceptance and checked from the input
//   register; the verdict is then registered in the output register. The rate
//   is set by the combinational state update between the input and state registers.
//   If the receiver stalls, the verdict holds in the output register; bytes that
//   are not last keep flowing, and a second last byte waits in the input
//   register, which drops in_beat.ready until the held verdict is taken.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   sequence state and error flag, so the next byte starts a new message.
//   Messages must hold at least one byte.
`timescale 1ns / 1ps

module utf8_text_validator_core
  import utv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  utv_in_if.sink      in_beat,
  utv_out_if.source   out_beat
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  utv_state_t state_r;
  utv_state_t state_nxt;
  utv_state_t step_state;
  logic       step_ok;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_ok_r;
  logic       out_free;
  logic       s1_fire;
  logic       in_fire;

  // Stage advance: a last byte needs room in the verdict register.
  assign out_free     = !out_valid_r || out_beat.ready;
  assign s1_fire      = s1_valid_r && (!s1_last_r || out_free);
  assign in_beat.ready = !s1_valid_r || s1_fire;
  assign in_fire      = in_beat.valid && in_beat.ready;

  utv_step u_step (
    .cur_state (state_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .nxt_state (step_state),
    .text_ok   (step_ok)
  );

  // Next values of the control registers.
  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
    state_nxt     = s1_fire ? step_state : state_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_beat.ready;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_beat.data_byte;
      s1_last_r <= in_beat.last_byte;
    end
    if (s1_fire && s1_last_r) begin
      out_ok_r <= step_ok;
    end
  end

  assign out_beat.valid   = out_valid_r;
  assign out_beat.text_ok = out_ok_r;

endmodule

/* src/utv_checker.sv */
// Port-level assertions for the UTF-8 text validator, bound to the top level.
`timescale 1ns / 1ps

module utv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_text_ok
);

  // The verdict register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("verdict present after reset");

  // A stalled verdict beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_ok))
    else $error("stalled verdict changed or dropped");

  // A new verdict follows a last byte accepted at the input, through the input and verdict registers.
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("verdict without a last byte");

  // The input side only stalls behind an untaken verdict.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held verdict");

endmodule

bind utf8_text_validator_core utv_checker u_utv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_beat.valid),
  .in_ready    (in_beat.ready),
  .in_last     (in_beat.last_byte),
  .out_valid   (out_beat.valid),
  .out_ready   (out_beat.ready),
  .out_text_ok (out_beat.text_ok)
);
